// ----- hw/rtl/rcg_pkg.sv -----
// Shared types, constants and the link quota table of the run-type code generator.
package rcg_pkg;

  // Widths of the column, row and code fields.
  localparam int unsigned ColBits   = 16;
  localparam int unsigned RowBits   = 16;
  localparam int unsigned CodeBits  = 4;
  localparam int unsigned QuotaBits = 2;
  localparam int unsigned StateBits = 3;

  // Merge machine states.
  localparam logic [StateBits-1:0] StIdle     = 3'd0;
  localparam logic [StateBits-1:0] StPrevLead = 3'd1;
  localparam logic [StateBits-1:0] StCurrLead = 3'd2;
  localparam logic [StateBits-1:0] StInside   = 3'd3;
  localparam logic [StateBits-1:0] StPrevGap  = 3'd4;
  localparam logic [StateBits-1:0] StCurrGap  = 3'd5;
  localparam logic [StateBits-1:0] StLast     = StCurrGap;

  // Run-type direction codes; zero means that no code is emitted.
  localparam logic [CodeBits-1:0] CodeNone = 4'd0;
  localparam logic [CodeBits-1:0] CodeDir1 = 4'd1;
  localparam logic [CodeBits-1:0] CodeDir2 = 4'd2;
  localparam logic [CodeBits-1:0] CodeDir3 = 4'd3;
  localparam logic [CodeBits-1:0] CodeDir4 = 4'd4;
  localparam logic [CodeBits-1:0] CodeDir5 = 4'd5;
  localparam logic [CodeBits-1:0] CodeDir6 = 4'd6;
  localparam logic [CodeBits-1:0] CodeDir7 = 4'd7;
  localparam logic [CodeBits-1:0] CodeDir8 = 4'd8;
  localparam logic [CodeBits-1:0] CodeDir9 = 4'd9;
  localparam logic [CodeBits-1:0] CodeDir10 = 4'd10;

  // Outcome of one merge step.
  typedef struct packed {
    logic [CodeBits-1:0]  code;
    logic [ColBits-1:0]   x;
    logic                 adv_prev;
    logic                 adv_curr;
    logic                 done;
    logic [StateBits-1:0] next_state;
  } step_res_t;

  // Link quota of each direction code.
  function automatic logic [QuotaBits-1:0] quota_of(input logic [CodeBits-1:0] code);
    logic [QuotaBits-1:0] q;
    case (code)
      CodeDir1:  q = 2'd2;
      CodeDir2:  q = 2'd1;
      CodeDir3:  q = 2'd1;
      CodeDir4:  q = 2'd1;
      CodeDir6:  q = 2'd1;
      CodeDir7:  q = 2'd1;
      CodeDir8:  q = 2'd1;
      CodeDir9:  q = 2'd2;
      default:   q = 2'd0;
    endcase
    return q;
  endfunction

endpackage

// ----- hw/rtl/rcg_merge_step.sv -----
// Combinational step of the six-state merge machine over two run-edge list heads.
module rcg_merge_step (
  input  logic [rcg_pkg::StateBits-1:0] state_i,
  input  logic [rcg_pkg::ColBits-1:0]   held_x_i,
  input  logic [rcg_pkg::ColBits-1:0]   prev_x_i,
  input  logic                          prev_end_i,
  input  logic [rcg_pkg::ColBits-1:0]   curr_x_i,
  input  logic                          curr_end_i,
  output rcg_pkg::step_res_t            res_o
);

  logic [rcg_pkg::ColBits:0] a_ext;
  logic [rcg_pkg::ColBits:0] b_ext;
  logic                      gt;
  logic                      lt;

  // An exhausted list reads as a column beyond every real one.
  assign a_ext = prev_end_i ? {1'b1, {rcg_pkg::ColBits{1'b0}}} : {1'b0, prev_x_i};
  assign b_ext = curr_end_i ? {1'b1, {rcg_pkg::ColBits{1'b0}}} : {1'b0, curr_x_i};
  assign gt    = a_ext > b_ext;
  assign lt    = a_ext < b_ext;

  // State transition, code choice and head consumption.
  always_comb begin
    res_o            = '0;
    res_o.code       = rcg_pkg::CodeNone;
    res_o.x          = held_x_i;
    res_o.next_state = rcg_pkg::StIdle;
    if (prev_end_i && curr_end_i) begin
      res_o.done = (state_i <= rcg_pkg::StLast);
    end else begin
      case (state_i)
        rcg_pkg::StIdle: begin
          if (gt) begin
            res_o.next_state = rcg_pkg::StCurrLead;
            res_o.x = curr_x_i; res_o.adv_curr = 1'b1;
          end else if (lt) begin
            res_o.next_state = rcg_pkg::StPrevLead;
            res_o.adv_prev = 1'b1;
          end else begin
            res_o.next_state = rcg_pkg::StInside; res_o.code = rcg_pkg::CodeDir2;
            res_o.x = curr_x_i; res_o.adv_prev = 1'b1; res_o.adv_curr = 1'b1;
          end
        end
        rcg_pkg::StPrevLead: begin
          if (gt) begin
            res_o.next_state = rcg_pkg::StInside; res_o.code = rcg_pkg::CodeDir4;
            res_o.x = curr_x_i; res_o.adv_curr = 1'b1;
          end else if (lt) begin
            res_o.next_state = rcg_pkg::StIdle; res_o.code = rcg_pkg::CodeDir5;
            res_o.x = prev_x_i; res_o.adv_prev = 1'b1;
          end else begin
            res_o.next_state = rcg_pkg::StPrevGap; res_o.code = rcg_pkg::CodeDir4;
            res_o.x = prev_x_i; res_o.adv_prev = 1'b1; res_o.adv_curr = 1'b1;
          end
        end
        rcg_pkg::StCurrLead: begin
          if (gt) begin
            res_o.next_state = rcg_pkg::StIdle; res_o.code = rcg_pkg::CodeDir1;
            res_o.adv_curr = 1'b1;
          end else if (lt) begin
            res_o.next_state = rcg_pkg::StInside; res_o.code = rcg_pkg::CodeDir3;
            res_o.adv_prev = 1'b1;
          end else begin
            res_o.next_state = rcg_pkg::StCurrGap; res_o.code = rcg_pkg::CodeDir3;
            res_o.adv_prev = 1'b1; res_o.adv_curr = 1'b1;
          end
        end
        rcg_pkg::StInside: begin
          if (gt) begin
            res_o.next_state = rcg_pkg::StCurrGap; res_o.adv_curr = 1'b1;
          end else if (lt) begin
            res_o.next_state = rcg_pkg::StPrevGap;
            res_o.x = prev_x_i; res_o.adv_prev = 1'b1;
          end else begin
            res_o.next_state = rcg_pkg::StIdle; res_o.code = rcg_pkg::CodeDir6;
            res_o.adv_prev = 1'b1; res_o.adv_curr = 1'b1;
          end
        end
        rcg_pkg::StPrevGap: begin
          if (gt) begin
            res_o.next_state = rcg_pkg::StIdle; res_o.code = rcg_pkg::CodeDir8;
            res_o.adv_curr = 1'b1;
          end else if (lt) begin
            res_o.next_state = rcg_pkg::StInside; res_o.code = rcg_pkg::CodeDir10;
            res_o.adv_prev = 1'b1;
          end else begin
            res_o.next_state = rcg_pkg::StCurrGap; res_o.code = rcg_pkg::CodeDir10;
            res_o.adv_prev = 1'b1; res_o.adv_curr = 1'b1;
          end
        end
        rcg_pkg::StCurrGap: begin
          if (gt) begin
            res_o.next_state = rcg_pkg::StInside; res_o.code = rcg_pkg::CodeDir9;
            res_o.x = curr_x_i; res_o.adv_curr = 1'b1;
          end else if (lt) begin
            res_o.next_state = rcg_pkg::StIdle; res_o.code = rcg_pkg::CodeDir7;
            res_o.x = prev_x_i; res_o.adv_prev = 1'b1;
          end else begin
            res_o.next_state = rcg_pkg::StPrevGap; res_o.code = rcg_pkg::CodeDir9;
            res_o.x = prev_x_i; res_o.adv_prev = 1'b1; res_o.adv_curr = 1'b1;
          end
        end
        default: begin
          res_o.next_state = rcg_pkg::StIdle;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/run_edge_rd_code_generator_top.sv -----
// Top level of the run-type direction code generator: input register, merge step, result register.
//
// The block walks the previous and current rows' run-edge lists one pair of heads per transfer
// and returns exactly one result per input transfer, in order. Throughput is one item per clock
// cycle while out_ready_i is held high; a low out_ready_i stalls it. Each item is captured in
// the input register, passes the merge step and is captured in the result register. The merge
// state and held column advance as an item moves from the input register to the result
// register, so consecutive items see each other's effect without bubbles. Row-done is raised
// when both heads are exhausted; the half-pixel offset of code_x_o is left to the consumer.
module run_edge_rd_code_generator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rcg_pkg::ColBits-1:0]   prev_x_i,
  input  logic                          prev_end_i,
  input  logic [rcg_pkg::ColBits-1:0]   curr_x_i,
  input  logic                          curr_end_i,
  input  logic [rcg_pkg::RowBits-1:0]   row_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcg_pkg::CodeBits-1:0]  code_o,
  output logic [rcg_pkg::ColBits-1:0]   code_x_o,
  output logic [rcg_pkg::RowBits-1:0]   code_row_o,
  output logic [rcg_pkg::QuotaBits-1:0] quota_o,
  output logic                          advance_prev_o,
  output logic                          advance_curr_o,
  output logic                          row_done_o
);

  // Input register.
  logic                          in_valid_q;
  logic [rcg_pkg::ColBits-1:0]   prev_x_q;
  logic                          prev_end_q;
  logic [rcg_pkg::ColBits-1:0]   curr_x_q;
  logic                          curr_end_q;
  logic [rcg_pkg::RowBits-1:0]   row_q;

  // Machine state.
  logic [rcg_pkg::StateBits-1:0] state_q;
  logic [rcg_pkg::ColBits-1:0]   held_x_q;

  // Result register.
  logic                          out_valid_q;
  logic [rcg_pkg::CodeBits-1:0]  code_q;
  logic [rcg_pkg::ColBits-1:0]   code_x_q;
  logic [rcg_pkg::RowBits-1:0]   code_row_q;
  logic [rcg_pkg::QuotaBits-1:0] quota_q;
  logic                          adv_prev_q;
  logic                          adv_curr_q;
  logic                          done_q;

  rcg_pkg::step_res_t            step_res;
  logic                          out_free;
  logic                          step_go;
  logic                          in_xfer;

  // Handshake: the result register frees when empty or taken, the input register follows.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_go    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step_go;
  assign in_xfer    = in_valid_i && in_ready_o;

  rcg_merge_step u_step (
    .state_i    (state_q),
    .held_x_i   (held_x_q),
    .prev_x_i   (prev_x_q),
    .prev_end_i (prev_end_q),
    .curr_x_i   (curr_x_q),
    .curr_end_i (curr_end_q),
    .res_o      (step_res)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= rcg_pkg::StIdle;
      held_x_q    <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (step_go) begin
        in_valid_q <= 1'b0;
      end
      if (step_go) begin
        out_valid_q <= 1'b1;
        state_q     <= step_res.next_state;
        held_x_q    <= step_res.x;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload capture.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      prev_x_q   <= prev_x_i;
      prev_end_q <= prev_end_i;
      curr_x_q   <= curr_x_i;
      curr_end_q <= curr_end_i;
      row_q      <= row_i;
    end
  end

  // Result payload capture.
  always_ff @(posedge clk_i) begin
    if (step_go) begin
      code_q     <= step_res.code;
      code_x_q   <= step_res.x;
      code_row_q <= (step_res.code != rcg_pkg::CodeNone) ? row_q : '0;
      quota_q    <= rcg_pkg::quota_of(step_res.code);
      adv_prev_q <= step_res.adv_prev;
      adv_curr_q <= step_res.adv_curr;
      done_q     <= step_res.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_o         = code_q;
  assign code_x_o       = code_x_q;
  assign code_row_o     = code_row_q;
  assign quota_o        = quota_q;
  assign advance_prev_o = adv_prev_q;
  assign advance_curr_o = adv_curr_q;
  assign row_done_o     = done_q;

`ifndef SYNTHESIS
  // The machine never leaves its six defined states.
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= rcg_pkg::StLast)
    else $error("merge state left the defined range");

  // A finished row emits no code and consumes no head.
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && row_done_o |->
      code_o == rcg_pkg::CodeNone && !advance_prev_o && !advance_curr_o)
    else $error("row done together with a code or an advance");

  // A finished row returns the machine to its idle state.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && step_res.done |=> state_q == rcg_pkg::StIdle)
    else $error("row done without return to idle");

  // A step that is not a finished row always consumes at least one head.
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && !(prev_end_q && curr_end_q) && state_q <= rcg_pkg::StLast |=>
      advance_prev_o || advance_curr_o)
    else $error("merge step consumed no head");

  // No code carries no row and no quota.
  a_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_o == rcg_pkg::CodeNone |-> code_row_o == '0 && quota_o == '0)
    else $error("row or quota given without a code");
`endif

endmodule
